FILE: hw/rtl/hbpe_pkg.sv
// Shared constants, codes and types of the Huffman bit-packing encoder.
package hbpe_pkg;

  localparam int MAX_CODE_LEN = 32;

  localparam int MODE_W = 2;
  localparam int SYM_W  = 8;
  localparam int LEN_W  = 6;
  localparam int CODE_W = 32;
  localparam int BYTE_W = 8;

  localparam int TABLE_DEPTH = 1 << SYM_W;

  localparam int ACC_W = MAX_CODE_LEN + BYTE_W;
  localparam int CNT_W = $clog2(ACC_W);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_CODE_LEN);

  localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ENCODE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FLUSH  = 2'd2;

  typedef struct packed {
    logic                    flush;
    logic [LEN_W-1:0]        len;
    logic [MAX_CODE_LEN-1:0] code;
  } hbpe_op_t;

endpackage

FILE: hw/rtl/hbpe_if.sv
// Valid/ready channel interfaces for the encoder input and output beats.
interface hbpe_in_if import hbpe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [SYM_W-1:0]  symbol;
  logic [LEN_W-1:0]  code_length;
  logic [CODE_W-1:0] code_bits;

  modport source(output valid, mode, symbol, code_length, code_bits, input ready);
  modport sink(input valid, mode, symbol, code_length, code_bits, output ready);
endinterface

interface hbpe_out_if import hbpe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last;

  modport source(output valid, out_byte, last, input ready);
  modport sink(input valid, out_byte, last, output ready);
endinterface

FILE: hw/rtl/hbpe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hbpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/hbpe_front.sv
// Front end: accepts beats, owns the code tables and builds packing operations.
module hbpe_front import hbpe_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  hbpe_in_if.sink  din,
  output logic     q_push,
  output hbpe_op_t q_op,
  input  logic     q_full
);

  logic                    accept;
  logic                    advance;
  logic                    load;
  logic [LEN_W-1:0]        len_sat;
  logic [TABLE_DEPTH-1:0]  valid_bits;
  logic                    s1_valid;
  logic [MODE_W-1:0]       s1_mode;
  logic                    s1_hit;
  logic [LEN_W-1:0]        len_rd;
  logic [CODE_W-1:0]       code_rd;
  logic [LEN_W-1:0]        s1_len;
  logic                    useful;

  assign accept  = din.valid && din.ready;
  assign load    = accept && (din.mode == MODE_LOAD);
  assign len_sat = (din.code_length > MAX_LEN) ? MAX_LEN : din.code_length;

  hbpe_ram #(.WIDTH(LEN_W), .DEPTH(TABLE_DEPTH)) u_len_ram (
    .clk   (clk),
    .we    (load),
    .waddr (din.symbol),
    .wdata (len_sat),
    .re    (accept),
    .raddr (din.symbol),
    .rdata (len_rd)
  );

  hbpe_ram #(.WIDTH(CODE_W), .DEPTH(TABLE_DEPTH)) u_code_ram (
    .clk   (clk),
    .we    (load),
    .waddr (din.symbol),
    .wdata (din.code_bits),
    .re    (accept),
    .raddr (din.symbol),
    .rdata (code_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
    end else if (load) begin
      valid_bits[din.symbol] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode <= din.mode;
      s1_hit  <= valid_bits[din.symbol];
    end
  end

  assign s1_len = s1_hit ? len_rd : '0;
  assign useful = ((s1_mode == MODE_ENCODE) && (s1_len != '0)) || (s1_mode == MODE_FLUSH);

  assign q_push    = s1_valid && useful && !q_full;
  assign advance   = !s1_valid || !useful || !q_full;
  assign din.ready = advance;

  assign q_op.flush = (s1_mode == MODE_FLUSH);
  assign q_op.len   = s1_len;
  assign q_op.code  = MAX_CODE_LEN'(code_rd) << (MAX_LEN - s1_len);

endmodule

FILE: hw/rtl/hbpe_queue.sv
// Short operation queue between the front end and the packer.
module hbpe_queue import hbpe_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  hbpe_op_t push_op,
  output logic     full,
  input  logic     pop,
  output hbpe_op_t pop_op,
  output logic     nonempty
);

  hbpe_op_t          entries [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;

  assign full     = (count == (QPTR_W + 1)'(QDEPTH));
  assign nonempty = (count != '0);
  assign pop_op   = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/hbpe_back.sv
// Packer: appends code bits to the bit accumulator and emits bytes one per cycle while the output is ready.
module hbpe_back import hbpe_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_nonempty,
  input  hbpe_op_t  q_op,
  output logic      q_pop,
  hbpe_out_if.source dout
);

  logic [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]  acc_next;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_next;
  logic              slot_free;
  logic              emit;
  logic              emit_last;
  logic              o_valid;
  logic [BYTE_W-1:0] o_byte;
  logic              o_last;

  assign slot_free = !o_valid || dout.ready;

  always_comb begin
    acc_next  = acc;
    cnt_next  = cnt;
    emit      = 1'b0;
    emit_last = 1'b0;
    q_pop     = 1'b0;
    priority if (cnt >= CNT_W'(BYTE_W)) begin
      if (slot_free) begin
        emit      = 1'b1;
        emit_last = (cnt < CNT_W'(2 * BYTE_W));
        acc_next  = acc << BYTE_W;
        cnt_next  = cnt - CNT_W'(BYTE_W);
      end
    end else if (q_nonempty) begin
      if (q_op.flush) begin
        if (cnt == '0) begin
          q_pop = 1'b1;
        end else if (slot_free) begin
          q_pop     = 1'b1;
          emit      = 1'b1;
          emit_last = 1'b1;
          acc_next  = '0;
          cnt_next  = '0;
        end
      end else begin
        q_pop    = 1'b1;
        acc_next = acc | ({q_op.code, {BYTE_W{1'b0}}} >> cnt);
        cnt_next = cnt + CNT_W'(q_op.len);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      cnt <= '0;
    end else begin
      acc <= acc_next;
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (emit) begin
      o_valid <= 1'b1;
    end else if (dout.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o_byte <= acc[ACC_W-1 -: BYTE_W];
      o_last <= emit_last;
    end
  end

  assign dout.valid    = o_valid;
  assign dout.out_byte = o_byte;
  assign dout.last     = o_last;

endmodule

FILE: hw/rtl/huffman_bit_packing_encoder.sv
// Table-driven Huffman bit-packing encoder top level.
// Path: an encode beat passes the table read registers, the queue, the bit accumulator and the output byte register.
// Throughput: one input beat per cycle at the front while the queue has room; the packer emits all pending
// bytes before it takes the next queued operation (up to four bytes per encode).
// Reset: synchronous; clears the length-table valid bits, queue and bit accumulator.
module huffman_bit_packing_encoder import hbpe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  hbpe_in_if.sink    din,
  hbpe_out_if.source dout
);

  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_nonempty;
  hbpe_op_t push_op;
  hbpe_op_t pop_op;

  hbpe_front u_front (
    .clk    (clk),
    .rst    (rst),
    .din    (din),
    .q_push (q_push),
    .q_op   (push_op),
    .q_full (q_full)
  );

  hbpe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_op  (push_op),
    .full     (q_full),
    .pop      (q_pop),
    .pop_op   (pop_op),
    .nonempty (q_nonempty)
  );

  hbpe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_op       (pop_op),
    .q_pop      (q_pop),
    .dout       (dout)
  );

endmodule
